@@ hdl/box_blur_3x3_edge_aware_defines.svh @@
// Assertion helpers
`ifndef BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/bb3_pkg.sv @@
package bb3_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int CfgW      = 11;
  localparam int StoreDepth = 3 * MaxWidth;
  localparam int AddrW     = $clog2(StoreDepth);

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;
    logic frame_done;
  } pix_out_t;

  // one output position to compute
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [1:0] slot_lo;   // line-store slot of row-1
    logic [1:0] slot_mid;
    logic [1:0] slot_hi;
    logic top;             // row-1 outside frame
    logic bot;             // row+1 outside frame
    logic lft;
    logic rgt;
    logic last;
  } job_t;

  // round(sum/n) half up for n in {1,2,3,4,6,9}, sum <= 9*255
  function automatic logic [7:0] round_mean(input logic [11:0] sum, input logic [3:0] n);
    logic [12:0] num;
    logic [25:0] prod;
    logic [12:0] q;
    logic [13:0] rem;
    logic [12:0] recip;
    num = {sum, 1'b0} + 13'(n);
    unique case (n)
      4'd1: recip = 13'd4096;
      4'd2: recip = 13'd2048;
      4'd3: recip = 13'd1366;
      4'd4: recip = 13'd1024;
      4'd6: recip = 13'd683;
      4'd9: recip = 13'd456;
      default: recip = 13'd4096;
    endcase
    prod = 26'(num) * 26'(recip);
    q = 13'(prod >> 13);
    // quotient may be one high; correct
    rem = 14'(num) - 14'(q) * 14'({n, 1'b0});
    if (rem[13]) q = q - 13'd1;
    return q[7:0];
  endfunction
endpackage

@@ hdl/bb3_ram.sv @@
module bb3_ram #(
  parameter int Width = 24,
  parameter int Depth = 3072
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/bb3_front.sv @@
module bb3_front (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [bb3_pkg::CfgW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  bb3_pkg::pix_in_t in_pix,
  output logic st_we,
  output logic [bb3_pkg::AddrW-1:0] st_addr,
  output logic [23:0] st_data,
  output logic job_valid,
  input  logic job_ready,
  output bb3_pkg::job_t job
);
  import bb3_pkg::*;

  logic [CfgW-1:0] width_reg, height_reg;
  logic [ColW:0] w_eff;
  logic [RowW:0] h_eff;
  logic [RowW-1:0] row;
  logic [ColW-1:0] col;
  logic [1:0] slot, slot_prev, slot_pp;
  // pending emissions for the accepted pixel: up to 4
  logic [3:0] pend;
  logic [RowW-1:0] p_row;
  logic [ColW-1:0] p_col;
  logic [1:0] p_slot, p_slot_prev, p_slot_pp;
  logic p_rprev, p_rcur, p_cprev, p_ccur;
  logic [1:0] sel;
  logic [RowW-1:0] e_row;
  logic [ColW-1:0] e_col;
  logic e_rowcur;
  logic busy;

  always_comb begin
    if (width_reg == '0) w_eff = (ColW+1)'(1);
    else if (width_reg > CfgW'(MaxWidth)) w_eff = (ColW+1)'(MaxWidth);
    else w_eff = (ColW+1)'(width_reg);
    if (height_reg == '0) h_eff = (RowW+1)'(1);
    else if (height_reg > CfgW'(MaxHeight)) h_eff = (RowW+1)'(MaxHeight);
    else h_eff = (RowW+1)'(height_reg);
  end

  assign busy = (pend != '0);
  // next pixel waits for the back to go idle, so its store write never overtakes a tap read
  assign in_ready = !busy && job_ready;
  assign st_we = in_valid && in_ready;
  assign st_addr = AddrW'(slot) * AddrW'(MaxWidth) + AddrW'(col);
  assign st_data = {in_pix.in_red, in_pix.in_green, in_pix.in_blue};

  // which outputs the incoming pixel completes
  always_comb begin
    p_rprev = (row != '0);
    p_rcur = ((RowW+1)'(row) == h_eff - (RowW+1)'(1));
    p_cprev = (col != '0);
    p_ccur = ((ColW+1)'(col) == w_eff - (ColW+1)'(1));
  end

  // pick the lowest pending emission: bits 0 to 3 are rprev&cprev, rprev&ccur, rcur&cprev, rcur&ccur
  always_comb begin
    priority if (pend[0]) sel = 2'd0;
    else if (pend[1]) sel = 2'd1;
    else if (pend[2]) sel = 2'd2;
    else sel = 2'd3;
    e_rowcur = sel[1];
    e_row = e_rowcur ? p_row : p_row - RowW'(1);
    e_col = sel[0] ? p_col : p_col - ColW'(1);
  end

  assign job_valid = busy;
  always_comb begin
    job.row = e_row;
    job.col = e_col;
    job.slot_mid = e_rowcur ? p_slot : p_slot_prev;
    job.slot_lo  = e_rowcur ? p_slot_prev : p_slot_pp;
    job.slot_hi  = p_slot;
    job.top = (e_row == '0);
    job.bot = ((RowW+1)'(e_row) == h_eff - (RowW+1)'(1));
    job.lft = (e_col == '0);
    job.rgt = ((ColW+1)'(e_col) == w_eff - (ColW+1)'(1));
    job.last = job.bot && job.rgt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= CfgW'(MaxWidth);
      height_reg <= CfgW'(MaxHeight);
      row <= '0;
      col <= '0;
      slot <= 2'd0;
      slot_prev <= 2'd2;
      slot_pp <= 2'd1;
      pend <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) width_reg <= cfg_data;
      else height_reg <= cfg_data;
      row <= '0;
      col <= '0;
      slot <= 2'd0;
      slot_prev <= 2'd2;
      slot_pp <= 2'd1;
    end else begin
      if (job_valid && job_ready) pend[sel] <= 1'b0;
      if (st_we) begin
        p_row <= row;
        p_col <= col;
        p_slot <= slot;
        p_slot_prev <= slot_prev;
        p_slot_pp <= slot_pp;
        pend <= {p_rcur && p_ccur, p_rcur && p_cprev, p_rprev && p_ccur, p_rprev && p_cprev};
        if ((ColW+1)'(col) == w_eff - (ColW+1)'(1)) begin
          col <= '0;
          if ((RowW+1)'(row) == h_eff - (RowW+1)'(1)) begin
            row <= '0;
            slot <= 2'd0;
            slot_prev <= 2'd2;
            slot_pp <= 2'd1;
          end else begin
            row <= row + RowW'(1);
            slot <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
            slot_prev <= slot;
            slot_pp <= slot_prev;
          end
        end else begin
          col <= col + ColW'(1);
        end
      end
    end
  end
endmodule

@@ hdl/bb3_back.sv @@
module bb3_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  bb3_pkg::job_t job,
  output logic [bb3_pkg::AddrW-1:0] rd_addr,
  input  logic [23:0] rd_data,
  output logic out_valid,
  input  logic out_ready,
  output bb3_pkg::pix_out_t out_pix
);
  import bb3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  job_t cur;
  logic [3:0] step;      // 0..8 tap index issued
  logic [3:0] step_d;
  logic tap_ok, tap_ok_d, rd_pend;
  logic [11:0] sum_r, sum_g, sum_b;
  logic [3:0] cnt;
  logic [1:0] tr, tc;
  logic [1:0] tslot;
  logic [ColW-1:0] tcol;

  always_comb begin
    tr = (step >= 4'd6) ? 2'd2 : (step >= 4'd3) ? 2'd1 : 2'd0;
    tc = 2'(step - 4'(tr) * 4'd3);
    unique case (tr)
      2'd0: tslot = cur.slot_lo;
      2'd1: tslot = cur.slot_mid;
      default: tslot = cur.slot_hi;
    endcase
    tcol = cur.col + ColW'(tc) - ColW'(1);
    tap_ok = !((tr == 2'd0) && cur.top) && !((tr == 2'd2) && cur.bot) &&
             !((tc == 2'd0) && cur.lft) && !((tc == 2'd2) && cur.rgt);
    rd_addr = AddrW'(tslot) * AddrW'(MaxWidth) + AddrW'(tcol);
  end

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_pend <= 1'b0;
      step <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            step <= '0;
            rd_pend <= 1'b0;
            sum_r <= '0; sum_g <= '0; sum_b <= '0; cnt <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (rd_pend && tap_ok_d) begin
            sum_r <= sum_r + 12'(rd_data[23:16]);
            sum_g <= sum_g + 12'(rd_data[15:8]);
            sum_b <= sum_b + 12'(rd_data[7:0]);
            cnt <= cnt + 4'd1;
          end
          if (step_d == 4'd8 && rd_pend) begin
            rd_pend <= 1'b0;
            state <= S_DONE;
          end else begin
            rd_pend <= 1'b1;
            tap_ok_d <= tap_ok;
            step_d <= step;
            if (step != 4'd8) step <= step + 4'd1;
          end
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_pix.out_red = round_mean(sum_r, cnt);
    out_pix.out_green = round_mean(sum_g, cnt);
    out_pix.out_blue = round_mean(sum_b, cnt);
    out_pix.out_row = cur.row;
    out_pix.out_col = cur.col;
    out_pix.frame_done = cur.last;
  end
endmodule

@@ hdl/box_blur_3x3_edge_aware.sv @@
// 3x3 box blur over an RGB raster stream, edge aware.
// Input: in_valid/in_ready with in_pix, one pixel per request, raster order.
// Output: out_valid/out_ready with out_pix: blurred channels, row, column
// and frame_done on the last pixel of the frame.
// Config: cfg_we/cfg_index/cfg_data write frame_width (0) or frame_height
// (1); every write restarts the frame at (0,0). Write only when idle.
// The front stores each pixel in a three-row line store and lists the
// outputs it completes (0 to 4); the back computes them one at a time.
// Each output reads its nine taps in turn through the single read port of the
// line store, so the front takes a new pixel only after the back has finished
// every output that the last pixel released.
// Reset: synchronous, active high; size back to 1024x1024, position (0,0).
// The line store is not cleared: taps outside the frame are read but not
// summed, and every summed entry is written within the frame before it is read.
// A stalled receiver holds the output; in_ready stays low until the back
// has finished every output of the last pixel.
module box_blur_3x3_edge_aware (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [bb3_pkg::CfgW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  bb3_pkg::pix_in_t in_pix,
  output logic out_valid,
  input  logic out_ready,
  output bb3_pkg::pix_out_t out_pix
);
  import bb3_pkg::*;
  `include "box_blur_3x3_edge_aware_defines.svh"

  logic st_we;
  logic [AddrW-1:0] st_addr, rd_addr;
  logic [23:0] st_data, rd_data;
  logic job_valid, job_ready;
  job_t job;

  bb3_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .in_pix,
    .st_we, .st_addr, .st_data, .job_valid, .job_ready, .job
  );

  bb3_ram #(.Width(24), .Depth(StoreDepth)) u_store (
    .clk, .we(st_we), .waddr(st_addr), .wdata(st_data),
    .raddr(rd_addr), .rdata(rd_data)
  );

  bb3_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .rd_addr, .rd_data,
    .out_valid, .out_ready, .out_pix
  );

  `BB_ASSERT(a_no_accept_when_pending, (job_valid |-> !in_ready), "accepted while busy")
  `BB_ASSERT(a_out_holds, (out_valid && !out_ready |=> out_valid && $stable(out_pix)),
             "output dropped under stall")
  `BB_ASSERT_RST(a_reset_idle, (rst |=> !out_valid), "output after reset")
endmodule
